>>> hdl/gfl_pkg.sv
// Shared types, codes and constants of the GF(2^m) log/antilog arithmetic unit.
`timescale 1ns / 1ps

package gfl_pkg;

  // Default sizes
  localparam int GFL_MAX_DEGREE = 8;
  localparam int GFL_CODE_BITS  = 64;
  localparam int GFL_WORD_W     = 64;   // codeword width held in the queue
  localparam int GFL_QDEPTH     = 2;    // front-to-back queue entries
  localparam int GFL_QPTR_W     = $clog2(GFL_QDEPTH);

  // Register reset values
  localparam logic [3:0] GFL_DEGREE_RST = 4'd8;
  localparam logic [8:0] GFL_POLY_RST   = 9'd285;

  // Register indexes
  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_POLY   = 1'b1;

  // Mode codes on the input stream
  localparam logic [2:0] MODE_MUL   = 3'd0;
  localparam logic [2:0] MODE_POW   = 3'd1;
  localparam logic [2:0] MODE_INV   = 3'd2;
  localparam logic [2:0] MODE_LOG   = 3'd3;
  localparam logic [2:0] MODE_ALPHA = 3'd4;
  localparam logic [2:0] MODE_SYN   = 3'd5;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    OP_ZERO,   // result is zero, no error
    OP_ERR,    // inverse or log of zero
    OP_MUL,
    OP_POW,
    OP_INV,
    OP_LOG,
    OP_ALPHA,
    OP_SYN
  } gfl_op_t;

  // One queued item, operands already masked to m bits
  typedef struct packed {
    gfl_op_t               op;
    logic [7:0]            a;
    logic [7:0]            b;
    logic [7:0]            e;
    logic [GFL_WORD_W-1:0] word;
  } gfl_item_t;

  // Field setup seen by front and back
  typedef struct packed {
    logic [3:0] degree;    // saturated m
    logic [8:0] poly;
    logic       rebuild;   // register write this cycle
  } gfl_cfg_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } gfl_qstat_t;

endpackage

>>> hdl/gf2m_log_table_arithmetic.sv
// Top level of the GF(2^m) log/antilog arithmetic unit.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  s_*      | s_tvalid/s_tready  | tuser: mode; tdata: a, b, power, codeword
//  m_*      | m_tvalid/m_tready  | tuser: error; tdata: value
//  cfg_*    | cfg_we             | cfg_index, cfg_data (no read-back)
//
// After reset or any register write the first item waits for a table build:
// the log table is cleared, then both tables are filled. With tables built,
// log and zero-operand items go from the log read straight to the output;
// multiply, power, inverse and alpha power also fold the exponent modulo
// 2^m-1 and read the antilog table. Syndrome folds the power and then walks
// the codeword bit by bit up to its highest set bit. The back end works one item
// at a time, set by its sequencer and the single antilog read port. A two-entry
// queue keeps the input taking beats while a result waits in the output register.
`timescale 1ns / 1ps

module gf2m_log_table_arithmetic #(
  parameter int MAX_DEGREE = gfl_pkg::GFL_MAX_DEGREE,
  parameter int CODE_BITS  = gfl_pkg::GFL_CODE_BITS,
  localparam int IN_W      = ((24 + CODE_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // operand_a, operand_b, power_value, codeword, zero pad
  input  logic [2:0]      s_tuser,   // mode
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // value
  output logic [0:0]      m_tuser,   // error
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [8:0]      cfg_data
);
  import gfl_pkg::*;

  logic [3:0] field_degree;
  logic [8:0] field_poly;
  gfl_cfg_t   cfg;
  gfl_qstat_t qstat;
  gfl_item_t  front_item;
  gfl_item_t  queue_item;
  logic       push;
  logic       pop;
  logic       tables_ready;
  logic       out_error;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      field_degree <= GFL_DEGREE_RST;
      field_poly   <= GFL_POLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGREE: field_degree <= cfg_data[3:0];
        REG_POLY:   field_poly   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated degree
  always_comb begin
    if (field_degree < 4'd2)
      cfg.degree = 4'd2;
    else if (int'(field_degree) > MAX_DEGREE)
      cfg.degree = 4'(MAX_DEGREE);
    else
      cfg.degree = field_degree;
    cfg.poly    = field_poly;
    cfg.rebuild = cfg_we;
  end

  gfl_front #(
    .CODE_BITS (CODE_BITS)
  ) u_front (
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .mode        (s_tuser),
    .operand_a   (s_tdata[7:0]),
    .operand_b   (s_tdata[15:8]),
    .power_value (s_tdata[23:16]),
    .codeword    (s_tdata[24 +: CODE_BITS]),
    .cfg         (cfg),
    .qstat       (qstat),
    .push        (push),
    .item        (front_item)
  );

  gfl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .pop   (pop),
    .dout  (queue_item),
    .qstat (qstat)
  );

  gfl_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .qstat        (qstat),
    .item         (queue_item),
    .item_pop     (pop),
    .tables_ready (tables_ready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_value    (m_tdata),
    .out_error    (out_error)
  );

  assign m_tuser = out_error;

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0))
    else $error("error beat carries a nonzero value");

  a_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !tables_ready)
    else $error("tables still marked ready after a register write");

  a_queue: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

endmodule

>>> hdl/gfl_front.sv
// Front end: accepts input beats, masks operands and classifies the operation.
`timescale 1ns / 1ps

module gfl_front #(
  parameter int CODE_BITS = gfl_pkg::GFL_CODE_BITS
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           mode,
  input  logic [7:0]           operand_a,
  input  logic [7:0]           operand_b,
  input  logic [7:0]           power_value,
  input  logic [CODE_BITS-1:0] codeword,
  input  gfl_pkg::gfl_cfg_t    cfg,
  input  gfl_pkg::gfl_qstat_t  qstat,
  output logic                 push,
  output gfl_pkg::gfl_item_t   item
);
  import gfl_pkg::*;

  logic [8:0] top9;
  logic [7:0] mask8;
  logic [7:0] a_m;
  logic [7:0] b_m;

  // Operand mask for the current degree
  always_comb begin
    top9  = 9'd1 << cfg.degree;
    mask8 = (cfg.degree >= 4'd8) ? 8'hFF : 8'(top9 - 9'd1);
    a_m   = operand_a & mask8;
    b_m   = operand_b & mask8;
  end

  // Classify; zero operands resolve here
  always_comb begin
    item.a    = a_m;
    item.b    = b_m;
    item.e    = power_value;
    item.word = GFL_WORD_W'(codeword);
    unique case (mode)
      MODE_MUL:   item.op = (a_m == 8'd0 || b_m == 8'd0) ? OP_ZERO : OP_MUL;
      MODE_POW:   item.op = (a_m == 8'd0) ? OP_ZERO : OP_POW;
      MODE_INV:   item.op = (a_m == 8'd0) ? OP_ERR : OP_INV;
      MODE_LOG:   item.op = (a_m == 8'd0) ? OP_ERR : OP_LOG;
      MODE_ALPHA: item.op = OP_ALPHA;
      MODE_SYN:   item.op = OP_SYN;
      default:    item.op = OP_ZERO;
    endcase
  end

  assign in_ready = !qstat.full;
  assign push     = in_valid && !qstat.full;

endmodule

>>> hdl/gfl_queue.sv
// Short queue between front end and back end.
`timescale 1ns / 1ps

module gfl_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gfl_pkg::gfl_item_t  din,
  input  logic                pop,
  output gfl_pkg::gfl_item_t  dout,
  output gfl_pkg::gfl_qstat_t qstat
);
  import gfl_pkg::*;

  gfl_item_t             slots [GFL_QDEPTH];
  logic [GFL_QPTR_W-1:0] wptr;
  logic [GFL_QPTR_W-1:0] rptr;
  logic [GFL_QPTR_W:0]   fill;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      fill <= fill + (GFL_QPTR_W+1)'(push) - (GFL_QPTR_W+1)'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= din;
  end

  assign dout        = slots[rptr];
  assign qstat.full  = (fill == (GFL_QPTR_W+1)'(GFL_QDEPTH));
  assign qstat.empty = (fill == '0);

endmodule

>>> hdl/gfl_back.sv
// Back end: builds the log/antilog tables and executes queued operations.
`timescale 1ns / 1ps

module gfl_back #(
  parameter int MAX_DEGREE = gfl_pkg::GFL_MAX_DEGREE
) (
  input  logic                clk,
  input  logic                rst,
  input  gfl_pkg::gfl_cfg_t   cfg,
  input  gfl_pkg::gfl_qstat_t qstat,
  input  gfl_pkg::gfl_item_t  item,
  output logic                item_pop,
  output logic                tables_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_value,
  output logic                out_error
);
  import gfl_pkg::*;

  localparam int W     = MAX_DEGREE;
  localparam int XW    = MAX_DEGREE + 8;   // log times 8-bit exponent
  localparam int DEPTH = 1 << MAX_DEGREE;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_BUILD, S_READ, S_CALC, S_FOLD, S_ANTI, S_SYN, S_OUT
  } state_t;

  state_t                state;
  gfl_item_t             cur;
  logic [W-1:0]          idx;
  logic [W-1:0]          ax;
  logic [XW-1:0]         x;
  logic [W-1:0]          res;
  logic                  res_err;
  logic [GFL_WORD_W-1:0] syn_word;
  logic [W-1:0]          syn_exp;
  logic [W-1:0]          syn_step;
  logic [W-1:0]          syn_acc;
  logic                  syn_pend;

  // Tables
  logic [W-1:0] log_mem  [DEPTH];
  logic [W-1:0] anti_mem [DEPTH];
  logic [W-1:0] la_q;
  logic [W-1:0] lb_q;
  logic [W-1:0] anti_q;

  // Combinational helpers
  logic [W:0]    top_w;
  logic [W-1:0]  mask_w;     // also the element count 2^m-1
  logic [W:0]    reduce_w;
  logic [W:0]    ax_shift;
  logic [W:0]    ax_red;
  logic [W-1:0]  ax_next;
  logic [XW-1:0] x_fold;
  logic          fold_done;
  logic [W-1:0]  r_fold;
  logic [W:0]    exp_sum;
  logic [W-1:0]  exp_next;
  logic [W-1:0]  acc_next;
  logic          log_we;
  logic [W-1:0]  log_waddr;
  logic [W-1:0]  log_wdata;
  logic          anti_we;
  logic [W-1:0]  anti_raddr;
  logic [W-1:0]  la_addr;
  logic [W-1:0]  lb_addr;

  // Field constants and the alpha step
  always_comb begin
    top_w    = (W+1)'(1) << cfg.degree;
    mask_w   = W'(top_w - 1'b1);
    reduce_w = ((W+1)'(cfg.poly) & (top_w - 1'b1)) | top_w;
    ax_shift = {ax, 1'b0};
    ax_red   = ((ax_shift & top_w) != '0) ? (ax_shift ^ reduce_w) : ax_shift;
    ax_next  = W'(ax_red) & mask_w;
  end

  // Mersenne fold: x mod (2^m-1), one fold per cycle
  always_comb begin
    x_fold    = (x & XW'(mask_w)) + (x >> cfg.degree);
    fold_done = (x <= XW'(mask_w));
    r_fold    = (x == XW'(mask_w)) ? '0 : W'(x);
  end

  // Syndrome exponent walk and accumulation
  always_comb begin
    exp_sum  = {1'b0, syn_exp} + {1'b0, syn_step};
    exp_next = (exp_sum >= {1'b0, mask_w}) ? W'(exp_sum - {1'b0, mask_w}) : W'(exp_sum);
    acc_next = syn_acc ^ (syn_pend ? anti_q : '0);
  end

  // Memory port selection
  always_comb begin
    log_we     = (state == S_CLEAR) || (state == S_BUILD);
    log_waddr  = (state == S_CLEAR) ? idx : ax;
    log_wdata  = (state == S_CLEAR) ? '0 : idx;
    anti_we    = (state == S_BUILD);
    anti_raddr = (state == S_SYN) ? syn_exp : r_fold;
    la_addr    = W'(cur.a);
    lb_addr    = W'(cur.b);
  end

  // Log table: one write, two reads
  always_ff @(posedge clk) begin
    if (log_we) log_mem[log_waddr] <= log_wdata;
    la_q <= log_mem[la_addr];
    lb_q <= log_mem[lb_addr];
  end

  // Antilog table: one write, one read
  always_ff @(posedge clk) begin
    if (anti_we) anti_mem[idx] <= ax;
    anti_q <= anti_mem[anti_raddr];
  end

  assign item_pop = (state == S_IDLE) && !qstat.empty;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tables_ready <= 1'b0;
      out_valid    <= 1'b0;
      syn_pend     <= 1'b0;
    end else begin
      // output beat taken with no new one behind it
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      // a register write invalidates the tables; the last build step marks them ready
      if (cfg.rebuild)
        tables_ready <= 1'b0;
      else if (state == S_BUILD && idx == mask_w - 1'b1)
        tables_ready <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            cur   <= item;
            idx   <= '0;
            state <= tables_ready ? S_READ : S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (idx == mask_w) begin
            idx   <= '0;
            ax    <= W'(1);
            state <= S_BUILD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_BUILD: begin
          ax  <= ax_next;
          idx <= idx + 1'b1;
          if (idx == mask_w - 1'b1) state <= S_READ;
        end
        S_READ: begin
          // log reads land in la_q / lb_q
          state <= S_CALC;
        end
        S_CALC: begin
          res_err <= (cur.op == OP_ERR);
          case (cur.op)
            OP_ZERO: begin
              res   <= '0;
              state <= S_OUT;
            end
            OP_ERR: begin
              res   <= '0;
              state <= S_OUT;
            end
            OP_MUL: begin
              x     <= XW'(la_q) + XW'(lb_q);
              state <= S_FOLD;
            end
            OP_POW: begin
              x     <= XW'(la_q) * XW'(cur.e);
              state <= S_FOLD;
            end
            OP_INV: begin
              x     <= (la_q == '0) ? '0 : XW'(mask_w - la_q);
              state <= S_FOLD;
            end
            OP_LOG: begin
              res   <= la_q;
              state <= S_OUT;
            end
            OP_ALPHA: begin
              x     <= XW'(cur.e);
              state <= S_FOLD;
            end
            OP_SYN: begin
              x     <= XW'(cur.e);
              state <= S_FOLD;
            end
            default:  state <= S_OUT;
          endcase
        end
        S_FOLD: begin
          if (!fold_done) begin
            x <= x_fold;
          end else if (cur.op == OP_SYN) begin
            syn_step <= r_fold;
            syn_exp  <= '0;
            syn_acc  <= '0;
            syn_pend <= 1'b0;
            syn_word <= cur.word;
            state    <= S_SYN;
          end else begin
            state <= S_ANTI;
          end
        end
        S_ANTI: begin
          res   <= anti_q;
          state <= S_OUT;
        end
        S_SYN: begin
          syn_acc <= acc_next;
          if (syn_word != '0) begin
            syn_pend <= syn_word[0];
            syn_word <= syn_word >> 1;
            syn_exp  <= exp_next;
          end else begin
            syn_pend <= 1'b0;
            res      <= acc_next;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_value <= 8'(res);
            out_error <= res_err;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
